// ===== sv/bitmap_slot_allocator_assert.svh =====
// Assertion macros for the slot allocator.
// Users provide clk and arst_n in the including scope.
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bsa_pkg.sv =====
// Shared types and constants of the bitmap slot allocator.
// No dependencies.
`default_nettype none

package bsa_pkg;

	localparam int WORD_BITS = 32;
	localparam int BIT_AW    = 5;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CW    = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE    = 1'd1;

	typedef enum logic {
		CMD_ALLOC   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_OOM       = 2'd1,
		ST_RELEASED  = 2'd2,
		ST_IGNORED   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_SCAN,
		S_MUL,
		S_DIV,
		S_CHK,
		S_RRD,
		S_RWR,
		S_PUT
	} state_t;

endpackage

`default_nettype wire

// ===== sv/bsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/bsa_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
// Depends on bsa_pkg.
`default_nettype none

module bsa_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [bsa_pkg::DIV_CW-1:0]    cnt_q;
	logic [15:0]                   rem_q;
	logic [15:0]                   dvs_q;
	logic [31:0]                   quo_q;
	logic [16:0]                   trial;
	logic [16:0]                   diff;
	logic                          ge;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + bsa_pkg::DIV_CW'(1);
			if (cnt_q == bsa_pkg::DIV_CW'(bsa_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== sv/bitmap_slot_allocator.sv =====
// Bitmap slot allocator: lowest-free-slot allocate and address-based release.
// Allocate: a read and a scan per 32-slot row scanned, then a multiply on a hit, and a load.
// Release: the bit-serial divider (32 steps), a range check and a row read-modify-write.
// One beat in flight; the input stalls until the result loads.
// Reset (async, active low) marks every slot free through per-row valid flags; no clearing pass.
`default_nettype none

module bitmap_slot_allocator #(
	parameter int CAPACITY = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [bsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [31:0]                      cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             command,
	input  wire logic [31:0]                      address,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [1:0]                            status,
	output logic [31:0]                           slot_address,
	output logic [5:0]                            slot_index
);

	localparam int NROWS     = (CAPACITY + bsa_pkg::WORD_BITS - 1) / bsa_pkg::WORD_BITS;
	localparam int ROW_AW    = (NROWS > 1) ? $clog2(NROWS) : 1;
	localparam int FIW       = ROW_AW + bsa_pkg::BIT_AW;
	localparam int LAST_BITS = CAPACITY - (NROWS - 1) * bsa_pkg::WORD_BITS;
	localparam logic [31:0] PAD_MASK =
		(LAST_BITS >= 32) ? 32'h0 : ~((32'h1 << LAST_BITS) - 32'h1);

	bsa_pkg::state_t  state_q, state_d;

	logic [31:0]               base_q;
	logic [15:0]               size_q;
	logic [NROWS-1:0]          row_valid_q;
	logic [ROW_AW-1:0]         row_q;
	logic [bsa_pkg::BIT_AW-1:0] bit_q;
	logic [FIW-1:0]            res_index_q;
	bsa_pkg::status_t          res_status_q;
	logic [31:0]               prod_q;

	logic                      out_valid_q;
	bsa_pkg::status_t          out_status_q;
	logic [31:0]               out_addr_q;
	logic [5:0]                out_index_q;

	logic                      in_acc;
	logic                      out_load;
	logic                      div_start;
	logic                      div_done;
	logic [31:0]               div_quo;
	logic                      ram_we;
	logic [31:0]               ram_wdata;
	logic [31:0]               ram_rdata;
	logic [31:0]               row_word;
	logic [31:0]               word_eff;
	logic [31:0]               zero_oh;
	logic                      found;
	logic [bsa_pkg::BIT_AW-1:0] bit_pos;
	logic                      last_row;
	logic                      rel_skip;
	logic [FIW+15:0]           mul_full;

	assign in_stall = (state_q != bsa_pkg::S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign rel_skip = (address == 32'd0) || (address < base_q);
	assign last_row = (row_q == ROW_AW'(NROWS - 1));

	assign row_word = row_valid_q[row_q] ? ram_rdata : 32'h0;
	assign word_eff = row_word | (last_row ? PAD_MASK : 32'h0);
	assign zero_oh  = ~word_eff & (word_eff + 32'd1);
	assign found    = |(~word_eff);

	always_comb begin
		bit_pos = '0;
		for (int j = 0; j < bsa_pkg::WORD_BITS; j++) begin
			if (zero_oh[j]) begin
				bit_pos = bit_pos | bsa_pkg::BIT_AW'(j);
			end
		end
	end

	assign mul_full = (FIW + 16)'(size_q) * (FIW + 16)'(res_index_q);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = row_word | zero_oh;
		out_load  = 1'b0;
		case (state_q)
			bsa_pkg::S_IDLE: begin
				if (in_acc) begin
					if (command == bsa_pkg::CMD_RELEASE) begin
						if (rel_skip) begin
							state_d = bsa_pkg::S_PUT;
						end else begin
							div_start = 1'b1;
							state_d   = bsa_pkg::S_DIV;
						end
					end else begin
						state_d = bsa_pkg::S_RD;
					end
				end
			end
			bsa_pkg::S_RD: state_d = bsa_pkg::S_SCAN;
			bsa_pkg::S_SCAN: begin
				if (found) begin
					ram_we  = 1'b1;
					state_d = bsa_pkg::S_MUL;
				end else if (last_row) begin
					state_d = bsa_pkg::S_PUT;
				end else begin
					state_d = bsa_pkg::S_RD;
				end
			end
			bsa_pkg::S_MUL: state_d = bsa_pkg::S_PUT;
			bsa_pkg::S_DIV: begin
				if (div_done) begin
					state_d = bsa_pkg::S_CHK;
				end
			end
			bsa_pkg::S_CHK: begin
				state_d = (div_quo >= 32'(CAPACITY)) ? bsa_pkg::S_PUT : bsa_pkg::S_RRD;
			end
			bsa_pkg::S_RRD: state_d = bsa_pkg::S_RWR;
			bsa_pkg::S_RWR: begin
				ram_we    = 1'b1;
				ram_wdata = row_word & ~(32'h1 << bit_q);
				state_d   = bsa_pkg::S_PUT;
			end
			bsa_pkg::S_PUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = bsa_pkg::S_IDLE;
				end
			end
			default: state_d = bsa_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 32'd0;
			size_q <= 16'd1;
		end else if (cfg_write) begin
			if (cfg_index == bsa_pkg::REG_BASE_ADDRESS) begin
				base_q <= cfg_data;
			end else if (cfg_index == bsa_pkg::REG_SLOT_SIZE) begin
				size_q <= (cfg_data[15:0] == 16'd0) ? 16'd1 : cfg_data[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				row_valid_q[row_q] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bsa_pkg::S_IDLE: begin
				row_q <= '0;
				if (command == bsa_pkg::CMD_RELEASE && rel_skip) begin
					res_status_q <= bsa_pkg::ST_IGNORED;
					res_index_q  <= '0;
				end
			end
			bsa_pkg::S_SCAN: begin
				if (found) begin
					res_status_q <= bsa_pkg::ST_ALLOCATED;
					res_index_q  <= {row_q, bit_pos};
				end else if (last_row) begin
					res_status_q <= bsa_pkg::ST_OOM;
					res_index_q  <= '0;
				end else begin
					row_q <= row_q + ROW_AW'(1);
				end
			end
			bsa_pkg::S_MUL: prod_q <= 32'(mul_full);
			bsa_pkg::S_CHK: begin
				row_q <= div_quo[FIW-1:bsa_pkg::BIT_AW];
				bit_q <= div_quo[bsa_pkg::BIT_AW-1:0];
				if (div_quo >= 32'(CAPACITY)) begin
					res_status_q <= bsa_pkg::ST_IGNORED;
					res_index_q  <= '0;
				end else begin
					res_status_q <= bsa_pkg::ST_RELEASED;
					res_index_q  <= div_quo[FIW-1:0];
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_status_q <= res_status_q;
			out_addr_q   <= (res_status_q == bsa_pkg::ST_ALLOCATED) ? base_q + prod_q : 32'd0;
			out_index_q  <= res_index_q[5:0];
		end
	end

	bsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (address - base_q),
		.divisor  (size_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	bsa_ram #(
		.WIDTH (bsa_pkg::WORD_BITS),
		.DEPTH (NROWS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_q),
		.wdata (ram_wdata),
		.raddr (row_q),
		.rdata (ram_rdata)
	);

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign slot_address = out_addr_q;
	assign slot_index   = out_index_q;

`include "bitmap_slot_allocator_assert.svh"

	`BSA_ASSERT_NXT(a_busy_after_accept, in_acc, in_stall, "no stall after accepted beat")
	`BSA_ASSERT_IMP(a_div_done_state, div_done, state_q == bsa_pkg::S_DIV, "divider done outside wait")
	`BSA_ASSERT_IMP(a_alloc_in_range, out_load && res_status_q == bsa_pkg::ST_ALLOCATED, 32'(res_index_q) < 32'(CAPACITY), "allocated index beyond capacity")
	`BSA_ASSERT_IMP(a_addr_zero, out_valid_q && out_status_q != bsa_pkg::ST_ALLOCATED, out_addr_q == 32'd0, "slot address set without allocation")

endmodule

`default_nettype wire

// ===== test/tb_bitmap_slot_allocator.sv =====
// Self-checking testbench for bitmap_slot_allocator: a directed table, then random
// phases over several register settings and idle patterns, checked against a local predictor.
// Depends on bsa_pkg and bitmap_slot_allocator.
module tb_bitmap_slot_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS         = 64;
	localparam int PHASES        = 8;
	localparam int PHASE_BEATS   = 155;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 60;
	localparam int PRINT_LIMIT   = 30;
	localparam int DIR_ROWS      = 20;

	typedef struct packed {
		bsa_pkg::status_t st;
		logic [31:0]      addr;
		logic [5:0]       idx;
	} slot_result_t;

	typedef struct packed {
		logic                          is_cfg;
		logic [bsa_pkg::CFG_IDX_W-1:0] reg_idx;
		bsa_pkg::cmd_t                 cmd;
		logic [31:0]                   value;
		logic [7:0]                    reps;
		logic                          fixed_want;
		slot_result_t                  want;
	} dir_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_write;
	logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0]                   cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic                          command;
	logic [31:0]                   address;
	logic                          out_valid;
	logic                          out_stall;
	logic [1:0]                    status;
	logic [31:0]                   slot_address;
	logic [5:0]                    slot_index;

	// predictor state
	logic [SLOTS-1:0] used_map;
	logic [31:0]      base_reg;
	logic [15:0]      size_reg;

	slot_result_t pending_results[$];
	dir_row_t     dir_tab [0:DIR_ROWS-1];

	int gap_pct;
	int stall_pct;
	int mismatch_count;
	int cycle_count;
	int alloc_seen;
	int oom_seen;
	int released_seen;
	int ignored_seen;

	bitmap_slot_allocator #(.CAPACITY(SLOTS)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.address      (address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.slot_address (slot_address),
		.slot_index   (slot_index)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic slot_result_t predict_slot(bsa_pkg::cmd_t cmd, logic [31:0] addr);
		logic [31:0]  eff;
		logic [31:0]  q;
		slot_result_t r;
		bit           found;
		eff = (size_reg == 16'd0) ? 32'd1 : {16'd0, size_reg};
		r = '{bsa_pkg::ST_IGNORED, 32'd0, 6'd0};
		found = 1'b0;
		if (cmd == bsa_pkg::CMD_ALLOC) begin
			r = '{bsa_pkg::ST_OOM, 32'd0, 6'd0};
			for (int i = 0; i < SLOTS; i++) begin
				if (!found && !used_map[i]) begin
					found = 1'b1;
					used_map[i] = 1'b1;
					r = '{bsa_pkg::ST_ALLOCATED, base_reg + eff * 32'(i), 6'(i)};
				end
			end
		end else if (addr != 32'd0 && addr >= base_reg) begin
			q = (addr - base_reg) / eff;
			if (q < SLOTS) begin
				used_map[q] = 1'b0;
				r = '{bsa_pkg::ST_RELEASED, 32'd0, q[5:0]};
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		slot_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("beat with nothing pending", {30'd0, status}, 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					report_mismatch("status", {30'd0, status}, {30'd0, want.st});
				if (slot_address !== want.addr)
					report_mismatch("slot_address", slot_address, want.addr);
				if (slot_index !== want.idx)
					report_mismatch("slot_index", {26'd0, slot_index}, {26'd0, want.idx});
				case (want.st)
					bsa_pkg::ST_ALLOCATED: alloc_seen++;
					bsa_pkg::ST_OOM:       oom_seen++;
					bsa_pkg::ST_RELEASED:  released_seen++;
					default:               ignored_seen++;
				endcase
			end
		end
	end

	task automatic send_beat(bsa_pkg::cmd_t c, logic [31:0] a, bit use_fixed,
		slot_result_t fixed);
		slot_result_t pred;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		address <= a;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = predict_slot(c, a);
		pending_results.push_back(use_fixed ? fixed : pred);
		@(negedge clk);
	endtask

	task automatic wait_results_done;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [bsa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		wait_results_done();
		repeat (2) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			bsa_pkg::REG_BASE_ADDRESS: base_reg = data;
			bsa_pkg::REG_SLOT_SIZE:    size_reg = data[15:0];
			default: ;
		endcase
	endtask

	initial begin
		logic [31:0]   a;
		logic [31:0]   eff;
		bsa_pkg::cmd_t c;
		int            roll;

		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = bsa_pkg::REG_BASE_ADDRESS;
		cfg_data  = 32'd0;
		in_valid  = 1'b0;
		command   = bsa_pkg::CMD_ALLOC;
		address   = 32'd0;
		out_stall = 1'b0;
		gap_pct   = 0;
		stall_pct = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		alloc_seen     = 0;
		oom_seen       = 0;
		released_seen  = 0;
		ignored_seen   = 0;
		used_map = '0;
		base_reg = 32'd0;
		size_reg = 16'd1;

		dir_tab[0]  = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_RELEASE, 32'h0, 8'd1, 1'b1,
			'{bsa_pkg::ST_IGNORED, 32'd0, 6'd0}};
		dir_tab[1]  = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_ALLOC, 32'h0, 8'd1, 1'b1,
			'{bsa_pkg::ST_ALLOCATED, 32'd0, 6'd0}};
		dir_tab[2]  = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_RELEASE, 32'h0, 8'd1, 1'b1,
			'{bsa_pkg::ST_IGNORED, 32'd0, 6'd0}};
		dir_tab[3]  = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_ALLOC, 32'hFFFF_FFFF,
			8'd1, 1'b1, '{bsa_pkg::ST_ALLOCATED, 32'd1, 6'd1}};
		dir_tab[4]  = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_RELEASE, 32'h1, 8'd1, 1'b1,
			'{bsa_pkg::ST_RELEASED, 32'd0, 6'd1}};
		dir_tab[5]  = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_RELEASE, 32'h1, 8'd1, 1'b1,
			'{bsa_pkg::ST_RELEASED, 32'd0, 6'd1}};
		dir_tab[6]  = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_RELEASE, 32'd64, 8'd1, 1'b1,
			'{bsa_pkg::ST_IGNORED, 32'd0, 6'd0}};
		dir_tab[7]  = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_RELEASE, 32'hFFFF_FFFF,
			8'd1, 1'b1, '{bsa_pkg::ST_IGNORED, 32'd0, 6'd0}};
		dir_tab[8]  = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_ALLOC, 32'h0, 8'd63, 1'b0,
			'{bsa_pkg::ST_IGNORED, 32'd0, 6'd0}};
		dir_tab[9]  = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_ALLOC, 32'h0, 8'd1, 1'b1,
			'{bsa_pkg::ST_OOM, 32'd0, 6'd0}};
		dir_tab[10] = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_RELEASE, 32'd63, 8'd1, 1'b1,
			'{bsa_pkg::ST_RELEASED, 32'd0, 6'd63}};
		dir_tab[11] = '{1'b1, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_ALLOC, 32'hFFFF_FF00,
			8'd1, 1'b0, '{bsa_pkg::ST_IGNORED, 32'd0, 6'd0}};
		dir_tab[12] = '{1'b1, bsa_pkg::REG_SLOT_SIZE, bsa_pkg::CMD_ALLOC, 32'h0000_FFFF,
			8'd1, 1'b0, '{bsa_pkg::ST_IGNORED, 32'd0, 6'd0}};
		dir_tab[13] = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_ALLOC, 32'h0, 8'd1, 1'b0,
			'{bsa_pkg::ST_IGNORED, 32'd0, 6'd0}};
		dir_tab[14] = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_RELEASE, 32'hFFFF_FEFF,
			8'd1, 1'b1, '{bsa_pkg::ST_IGNORED, 32'd0, 6'd0}};
		dir_tab[15] = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_RELEASE, 32'hFFFF_FFFF,
			8'd1, 1'b0, '{bsa_pkg::ST_IGNORED, 32'd0, 6'd0}};
		dir_tab[16] = '{1'b1, bsa_pkg::REG_SLOT_SIZE, bsa_pkg::CMD_ALLOC, 32'h0, 8'd1, 1'b0,
			'{bsa_pkg::ST_IGNORED, 32'd0, 6'd0}};
		dir_tab[17] = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_RELEASE, 32'hFFFF_FF3F,
			8'd1, 1'b0, '{bsa_pkg::ST_IGNORED, 32'd0, 6'd0}};
		dir_tab[18] = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_ALLOC, 32'h0, 8'd1, 1'b0,
			'{bsa_pkg::ST_IGNORED, 32'd0, 6'd0}};
		dir_tab[19] = '{1'b0, bsa_pkg::REG_BASE_ADDRESS, bsa_pkg::CMD_ALLOC, 32'h0, 8'd1, 1'b0,
			'{bsa_pkg::ST_IGNORED, 32'd0, 6'd0}};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_tab[r].is_cfg)
				write_reg(dir_tab[r].reg_idx, dir_tab[r].value);
			else
				repeat (dir_tab[r].reps)
					send_beat(dir_tab[r].cmd, dir_tab[r].value, dir_tab[r].fixed_want,
						dir_tab[r].want);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					write_reg(bsa_pkg::REG_BASE_ADDRESS, 32'd0);
					write_reg(bsa_pkg::REG_SLOT_SIZE, 32'd1);
				end
				1: begin
					write_reg(bsa_pkg::REG_BASE_ADDRESS, 32'hFFFF_FFFF);
					write_reg(bsa_pkg::REG_SLOT_SIZE, 32'h0000_FFFF);
				end
				2: begin
					write_reg(bsa_pkg::REG_BASE_ADDRESS, 32'h1000);
					write_reg(bsa_pkg::REG_SLOT_SIZE, 32'd16);
				end
				3: begin
					write_reg(bsa_pkg::REG_BASE_ADDRESS, $urandom);
					write_reg(bsa_pkg::REG_SLOT_SIZE, $urandom_range(65535, 1));
				end
				4: begin
					write_reg(bsa_pkg::REG_BASE_ADDRESS, 32'd0);
					write_reg(bsa_pkg::REG_SLOT_SIZE, 32'hFFFF);
				end
				5: begin
					write_reg(bsa_pkg::REG_BASE_ADDRESS, $urandom_range(255, 1));
					write_reg(bsa_pkg::REG_SLOT_SIZE, 32'd1);
				end
				6: begin
					write_reg(bsa_pkg::REG_BASE_ADDRESS, $urandom_range(32'h7FFF_FFFF, 0));
					write_reg(bsa_pkg::REG_SLOT_SIZE, $urandom_range(64, 1));
				end
				default: begin
					write_reg(bsa_pkg::REG_BASE_ADDRESS, 32'hFFFF_0000);
					write_reg(bsa_pkg::REG_SLOT_SIZE, 32'd1);
				end
			endcase
			case (phase % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 82; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 82; end
				default: begin gap_pct = 34; stall_pct = 34; end
			endcase
			eff = (size_reg == 16'd0) ? 32'd1 : {16'd0, size_reg};
			for (int k = 0; k < PHASE_BEATS; k++) begin
				if (phase == 1 && k == PHASE_BEATS / 2)
					wait_results_done();
				roll = $urandom_range(99);
				a = $urandom;
				c = bsa_pkg::CMD_RELEASE;
				if (roll < 42) begin
					c = bsa_pkg::CMD_ALLOC;
				end else if (roll < 85) begin
					a = base_reg + eff * $urandom_range(SLOTS - 1, 0) + $urandom_range(eff - 1, 0);
				end else begin
					case ($urandom_range(4, 0))
						0: a = 32'd0;
						1: a = base_reg - 32'd1;
						2: a = base_reg + eff * SLOTS + $urandom_range(3, 0);
						3: a = $urandom;
						default: a = base_reg + eff * SLOTS - 32'd1;
					endcase
				end
				send_beat(c, a, 1'b0, '0);
			end
		end

		wait_results_done();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Beats checked: %0d allocated, %0d out of memory, %0d released, %0d ignored",
			alloc_seen, oom_seen, released_seen, ignored_seen);
		$display("Directed table plus %0d random phases over base and size extremes and idle mixes",
			PHASES);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
